@@ rtl/fltpw_pkg.sv @@
// Shared types, codes and helper functions of the four-level page table walker.
`default_nettype none
package fltpw_pkg;

  localparam int unsigned INDEX_BITS = 9;
  localparam int unsigned PA_BITS    = 52;
  localparam int unsigned VA_BITS    = 48;
  localparam int unsigned ENTRY_BITS = 64;
  localparam int unsigned LVL_BITS   = 3;
  localparam int unsigned ATTR_BITS  = 8;

  // Operation codes of an input item.
  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_RESPONSE  = 1'b1;

  // Kinds of a result item.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Walk levels: idle, then the level whose entry is awaited.
  localparam logic [LVL_BITS-1:0] LVL_IDLE = 3'd0;
  localparam logic [LVL_BITS-1:0] LVL_PML4 = 3'd1;
  localparam logic [LVL_BITS-1:0] LVL_PDPT = 3'd2;
  localparam logic [LVL_BITS-1:0] LVL_PD   = 3'd3;
  localparam logic [LVL_BITS-1:0] LVL_PT   = 3'd4;

  // Entry bit positions.
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_USER    = 2;
  localparam int unsigned BIT_SIZE    = 7;

  localparam logic [ATTR_BITS-1:0] ATTR_NOT_FOUND = 8'hFF;

  typedef struct packed {
    logic                  operation;
    logic [VA_BITS-1:0]    virtual_address;
    logic [ENTRY_BITS-1:0] read_data;
  } fltpw_item_t;

  typedef struct packed {
    logic                 result_kind;
    logic [PA_BITS-1:0]   read_address;
    logic                 found;
    logic [PA_BITS-1:0]   physical_address;
    logic                 user_access;
    logic                 large_page;
    logic [ATTR_BITS-1:0] attribute;
  } fltpw_result_t;

  // Table index of a virtual address at a given level.
  function automatic logic [INDEX_BITS-1:0] level_index(
    input logic [VA_BITS-1:0]  va,
    input logic [LVL_BITS-1:0] lvl
  );
    logic [INDEX_BITS-1:0] idx;
    case (lvl)
      LVL_PML4: idx = va[39 +: INDEX_BITS];
      LVL_PDPT: idx = va[30 +: INDEX_BITS];
      LVL_PD:   idx = va[21 +: INDEX_BITS];
      LVL_PT:   idx = va[12 +: INDEX_BITS];
      default:  idx = '0;
    endcase
    return idx;
  endfunction

  // Address of an entry: table base plus eight times the index, wrapping.
  function automatic logic [PA_BITS-1:0] entry_address(
    input logic [PA_BITS-1:0]    base,
    input logic [INDEX_BITS-1:0] idx
  );
    return base + {{(PA_BITS-INDEX_BITS-3){1'b0}}, idx, 3'b000};
  endfunction

endpackage
`default_nettype wire

@@ rtl/fltpw_in_stage.sv @@
// Input register stage that holds one accepted item until it is processed.
`default_nettype none
module fltpw_in_stage
  import fltpw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire fltpw_item_t item_i,
  input  wire logic        advance_i,
  output logic             valid_o,
  output fltpw_item_t      item_o
);

  logic        valid_q, valid_d;
  fltpw_item_t item_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

@@ rtl/fltpw_step.sv @@
// Next-state and result logic for one walk step.
`default_nettype none
module fltpw_step
  import fltpw_pkg::*;
(
  input  wire fltpw_item_t          item_i,
  input  wire logic [LVL_BITS-1:0]  walk_level_i,
  input  wire logic [VA_BITS-1:0]   pending_address_i,
  input  wire logic [PA_BITS-1:0]   root_table_base_i,
  output logic                      has_result_o,
  output fltpw_result_t             result_o,
  output logic [LVL_BITS-1:0]       walk_level_o,
  output logic [VA_BITS-1:0]        pending_address_o
);

  logic [PA_BITS-1:0]  leaf_base;
  logic [LVL_BITS-1:0] next_level;
  fltpw_result_t       read_res;
  fltpw_result_t       done_res;

  assign leaf_base  = {item_i.read_data[PA_BITS-1:12], 12'b0};
  assign next_level = walk_level_i + LVL_BITS'(1);

  always_comb begin
    read_res             = '0;
    read_res.result_kind = KIND_READ;
    done_res             = '0;
    done_res.result_kind = KIND_DONE;
    done_res.found       = 1'b1;
    done_res.user_access = item_i.read_data[BIT_USER];
    done_res.attribute   = {5'b0, item_i.read_data[11:9]};

    has_result_o      = 1'b0;
    result_o          = read_res;
    walk_level_o      = walk_level_i;
    pending_address_o = pending_address_i;

    if (item_i.operation == OP_TRANSLATE) begin
      pending_address_o     = item_i.virtual_address;
      walk_level_o          = LVL_PML4;
      has_result_o          = 1'b1;
      result_o.read_address = entry_address(root_table_base_i,
                                level_index(item_i.virtual_address, LVL_PML4));
    end else if (!(walk_level_i inside {[LVL_PML4:LVL_PT]})) begin
      // A response with no walk in progress is dropped.
      walk_level_o = LVL_IDLE;
    end else begin
      has_result_o = 1'b1;
      if (!item_i.read_data[BIT_PRESENT]) begin
        walk_level_o       = LVL_IDLE;
        result_o           = '0;
        result_o.result_kind = KIND_DONE;
        result_o.attribute = ATTR_NOT_FOUND;
      end else if (walk_level_i == LVL_PD && item_i.read_data[BIT_SIZE]) begin
        walk_level_o              = LVL_IDLE;
        result_o                  = done_res;
        result_o.large_page       = 1'b1;
        result_o.physical_address = leaf_base
          + {{(PA_BITS-21){1'b0}}, pending_address_i[20:0]};
      end else if (walk_level_i == LVL_PT) begin
        walk_level_o              = LVL_IDLE;
        result_o                  = done_res;
        result_o.physical_address = leaf_base
          + {{(PA_BITS-12){1'b0}}, pending_address_i[11:0]};
      end else begin
        walk_level_o          = next_level;
        result_o.read_address = entry_address(leaf_base,
                                  level_index(pending_address_i, next_level));
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/four_level_page_table_walker_core.sv @@
// Top level of the four-level page table walker: walk state and result register.
`default_nettype none
// Walks a four-level x86-64 style page table held in external memory. A
// translate transfer (operation 0) starts a walk and yields a read request
// for the top-level entry; each response transfer (operation 1) yields either
// the next read request or the finished translation (not found if the entry
// is not present), with a 2 MiB leaf ending the walk at the directory level.
// A response while idle yields nothing. Each item passes an input register
// and then a result register before its result is valid at the output; one
// item is taken per cycle as long as results are taken, and the rate is set
// by the combinational step logic between the two registers. The root table
// base is written through cfg_we_i/cfg_wdata_i; the user must write it only
// while no walk is being processed, as the block itself does not enforce it.
module four_level_page_table_walker_core
  import fltpw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [PA_BITS-1:0]    cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  operation_i,
  input  wire logic [VA_BITS-1:0]    virtual_address_i,
  input  wire logic [ENTRY_BITS-1:0] read_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       result_kind_o,
  output logic [PA_BITS-1:0]         read_address_o,
  output logic                       found_o,
  output logic [PA_BITS-1:0]         physical_address_o,
  output logic                       user_access_o,
  output logic                       large_page_o,
  output logic [ATTR_BITS-1:0]       attribute_o
);

  fltpw_item_t         in_item;
  fltpw_item_t         s1_item;
  logic                s1_valid;
  logic                s1_advance;
  logic                step_has_result;
  fltpw_result_t       step_result;
  logic [LVL_BITS-1:0] step_level;
  logic [VA_BITS-1:0]  step_pending;

  logic [PA_BITS-1:0]  root_q;
  logic [LVL_BITS-1:0] walk_level_q;
  logic [VA_BITS-1:0]  pending_address_q;
  logic                out_valid_q, out_valid_d;
  fltpw_result_t       out_q;

  assign in_item.operation       = operation_i;
  assign in_item.virtual_address = virtual_address_i;
  assign in_item.read_data       = read_data_i;

  // The held item moves on when the result register is free or being drained.
  assign s1_advance = s1_valid && (!out_valid_q || out_ready_i);

  fltpw_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (s1_advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  fltpw_step u_step (
    .item_i            (s1_item),
    .walk_level_i      (walk_level_q),
    .pending_address_i (pending_address_q),
    .root_table_base_i (root_q),
    .has_result_o      (step_has_result),
    .result_o          (step_result),
    .walk_level_o      (step_level),
    .pending_address_o (step_pending)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_advance) begin
      out_valid_d = step_has_result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q            <= '0;
      walk_level_q      <= LVL_IDLE;
      pending_address_q <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      if (s1_advance) begin
        walk_level_q      <= step_level;
        pending_address_q <= step_pending;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_q <= step_result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = out_q.result_kind;
  assign read_address_o     = out_q.read_address;
  assign found_o            = out_q.found;
  assign physical_address_o = out_q.physical_address;
  assign user_access_o      = out_q.user_access;
  assign large_page_o       = out_q.large_page;
  assign attribute_o        = out_q.attribute;

endmodule
`default_nettype wire
